@@ rtl/nsfc_pkg.sv @@
// ----------------------------------------------------------------------------
// NMEA sentence framer package
// Character codes, limits and small helpers shared by the framer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package nsfc_pkg;

  // Longest sentence kept, from the dollar sign through the terminator.
  localparam int unsigned MAX_LEN = 128;
  localparam logic [7:0] LEN_LIMIT = 8'(MAX_LEN - 1);

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF_HEX = 8'h66;

  // "GGA", first character in the top byte.
  localparam logic [23:0] SENTENCE_TYPE_RST = 24'h474741;

  // One finished sentence report from the parser.
  typedef struct packed {
    logic       valid;
    logic [7:0] computed_checksum;
    logic [7:0] received_checksum;
    logic       checksum_ok;
    logic [7:0] sentence_length;
  } nsfc_result_t;

  // Returns {is_hex, nibble}.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= CH_0 && c <= CH_9) begin
      r = {1'b1, 4'(c - CH_0)};
    end else if (c >= CH_UA && c <= CH_UF) begin
      r = {1'b1, 4'(c - CH_UA + 8'd10)};
    end else if (c >= CH_LA && c <= CH_LF_HEX) begin
      r = {1'b1, 4'(c - CH_LA + 8'd10)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/nsfc_parser.sv @@
// ----------------------------------------------------------------------------
// NMEA sentence parser
// Holds the framing state and advances it by one character per step.
// ----------------------------------------------------------------------------
`default_nettype none

module nsfc_parser
  import nsfc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         step_en,
  input  wire logic [7:0]   rx_byte,
  input  wire logic [23:0]  sentence_type,
  output nsfc_result_t      result
);

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_ADDR = 2'd1,
    PH_BODY = 2'd2,
    PH_SUM  = 2'd3
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] position_r, position_nxt;
  logic       type_match_r, type_match_nxt;
  logic [7:0] running_xor_r, running_xor_nxt;
  logic [1:0] digit_count_r, digit_count_nxt;
  logic [7:0] digit_value_r, digit_value_nxt;

  logic       term;
  logic [4:0] hex;
  logic [7:0] want;
  logic       cmp_slot;
  logic [7:0] pos_inc;

  assign term    = (rx_byte == CH_CR) || (rx_byte == CH_LF);
  assign hex     = hex_decode(rx_byte);
  assign pos_inc = position_r + 8'd1;

  // Address characters three to five are compared against the type bytes.
  always_comb begin
    want     = 8'd0;
    cmp_slot = 1'b0;
    case (position_r)
      8'd3: begin
        want     = sentence_type[23:16];
        cmp_slot = 1'b1;
      end
      8'd4: begin
        want     = sentence_type[15:8];
        cmp_slot = 1'b1;
      end
      8'd5: begin
        want     = sentence_type[7:0];
        cmp_slot = 1'b1;
      end
      default: begin
        want     = 8'd0;
        cmp_slot = 1'b0;
      end
    endcase
  end

  always_comb begin
    phase_nxt       = phase_r;
    position_nxt    = position_r;
    type_match_nxt  = type_match_r;
    running_xor_nxt = running_xor_r;
    digit_count_nxt = digit_count_r;
    digit_value_nxt = digit_value_r;

    result.valid             = 1'b0;
    result.computed_checksum = running_xor_r;
    result.received_checksum = digit_value_r;
    result.checksum_ok       = (digit_count_r == 2'd2) && (digit_value_r == running_xor_r);
    result.sentence_length   = pos_inc;

    case (phase_r)
      PH_WAIT: begin
        if (rx_byte == CH_DOLLAR) begin
          phase_nxt       = PH_ADDR;
          position_nxt    = 8'd1;
          type_match_nxt  = 1'b1;
          running_xor_nxt = 8'd0;
          digit_count_nxt = 2'd0;
          digit_value_nxt = 8'd0;
        end
      end
      PH_ADDR: begin
        if (term) begin
          phase_nxt = PH_WAIT;
        end else begin
          running_xor_nxt = running_xor_r ^ rx_byte;
          if (cmp_slot && (rx_byte != want)) begin
            type_match_nxt = 1'b0;
          end
          position_nxt = pos_inc;
          if (pos_inc >= 8'd6) begin
            // The last address character decides; include this one's compare.
            if (type_match_r && !(cmp_slot && (rx_byte != want))) begin
              phase_nxt = PH_BODY;
            end else begin
              phase_nxt = PH_WAIT;
            end
          end
        end
      end
      PH_BODY: begin
        if (term || (position_r >= LEN_LIMIT)) begin
          phase_nxt = PH_WAIT;
        end else begin
          if (rx_byte == CH_STAR) begin
            phase_nxt       = PH_SUM;
            digit_count_nxt = 2'd0;
            digit_value_nxt = 8'd0;
          end else begin
            running_xor_nxt = running_xor_r ^ rx_byte;
          end
          position_nxt = pos_inc;
        end
      end
      PH_SUM: begin
        if (term) begin
          result.valid = 1'b1;
          phase_nxt    = PH_WAIT;
        end else if (position_r >= LEN_LIMIT) begin
          phase_nxt = PH_WAIT;
        end else begin
          if ((digit_count_r < 2'd2) && hex[4]) begin
            digit_value_nxt = {digit_value_r[3:0], hex[3:0]};
            digit_count_nxt = digit_count_r + 2'd1;
          end else begin
            digit_count_nxt = 2'd3;
          end
          position_nxt = pos_inc;
        end
      end
      default: begin
        phase_nxt = PH_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_WAIT;
      position_r    <= 8'd0;
      type_match_r  <= 1'b0;
      running_xor_r <= 8'd0;
      digit_count_r <= 2'd0;
      digit_value_r <= 8'd0;
    end else if (step_en) begin
      phase_r       <= phase_nxt;
      position_r    <= position_nxt;
      type_match_r  <= type_match_nxt;
      running_xor_r <= running_xor_nxt;
      digit_count_r <= digit_count_nxt;
      digit_value_r <= digit_value_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/nmea_sentence_framer_checksum.sv @@
// ----------------------------------------------------------------------------
// NMEA 0183 sentence framer with checksum check
// Frames sentences of the configured type and reports their checksums.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall, in_rx_byte) carries one received
//   character per word. The block waits for a dollar sign, checks address
//   characters three to five against cfg sentence_type, XORs the characters
//   up to the asterisk and captures the hex digits after it.
//   On the CR or LF that ends a sentence, one word leaves on the result
//   channel (out_valid, out_stall, out_*): computed and received checksum,
//   a match flag and the sentence length. Dropped sentences give no word.
//   A character is registered in the input register at acceptance, the
//   parser steps on it there and its result is registered in the result
//   register, which drives out_valid. Throughput is one character per
//   cycle unless a result waits in the input register on out_stall; the
//   parser step lies between the two registers.
//   While out_stall holds a result, characters that give no result still
//   flow; a second result waits in the input register, and only then does
//   in_stall rise.
//   Synchronous reset (rst_n low) empties both registers, returns the
//   parser to waiting for a dollar sign and loads the type "GGA".
//   cfg_wr_en writes cfg_sentence_type; write it only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module nmea_sentence_framer_checksum
  import nsfc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [7:0]  in_rx_byte,

  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [7:0]  out_computed_checksum,
  output      logic [7:0]  out_received_checksum,
  output      logic        out_checksum_ok,
  output      logic [7:0]  out_sentence_length,

  input  wire logic        cfg_wr_en,
  input  wire logic [23:0] cfg_sentence_type
);

  logic [23:0]  sentence_type_r;

  // Input register holding the character being parsed.
  logic         s1_valid_r;
  logic [7:0]   s1_byte_r;

  // Result register.
  logic         out_valid_r;
  logic [7:0]   out_computed_r;
  logic [7:0]   out_received_r;
  logic         out_ok_r;
  logic [7:0]   out_length_r;

  nsfc_result_t res;
  logic         out_free;
  logic         s1_adv;
  logic         in_take;

  nsfc_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_en       (s1_adv),
    .rx_byte       (s1_byte_r),
    .sentence_type (sentence_type_r),
    .result        (res)
  );

  // The result register can take a word when empty or being drained now.
  assign out_free = !out_valid_r || !out_stall;
  // A character without a result never waits for the output side.
  assign s1_adv   = s1_valid_r && (!res.valid || out_free);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sentence_type_r <= SENTENCE_TYPE_RST;
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        sentence_type_r <= cfg_sentence_type;
      end
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (out_free) begin
        out_valid_r <= s1_adv && res.valid;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_rx_byte;
    end
    if (out_free && s1_adv && res.valid) begin
      out_computed_r <= res.computed_checksum;
      out_received_r <= res.received_checksum;
      out_ok_r       <= res.checksum_ok;
      out_length_r   <= res.sentence_length;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_computed_checksum = out_computed_r;
  assign out_received_checksum = out_received_r;
  assign out_checksum_ok       = out_ok_r;
  assign out_sentence_length   = out_length_r;

endmodule

`default_nettype wire
